// ----- hdl/gn2d_pkg.sv -----
package gn2d_pkg;

  localparam int TABLE_SIZE_DEF = 256;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int OUT_FRAC       = 14;

  localparam int COORD_W = 24;
  localparam int ENTRY_W = 8;
  localparam int HASH_W  = 3;
  localparam int NOISE_W = 16;
  localparam int LEVEL_W = 4;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  localparam int FADE_C6  = 6;
  localparam int FADE_C15 = 15;
  localparam int FADE_C10 = 10;

  localparam int NOISE_MAX   = 32767;
  localparam int NOISE_MIN   = -32768;
  localparam int LEVEL_SCALE = 9;
  localparam int LEVEL_MIN   = 1;
  localparam int LEVEL_MAX   = 10;

  typedef struct packed {
    logic signed [1:0] gx;
    logic signed [1:0] gy;
  } grad_t;

  localparam grad_t GRAD_DIR [0:7] = '{
    '{2'sb01, 2'sb01}, '{2'sb11, 2'sb01}, '{2'sb01, 2'sb11}, '{2'sb11, 2'sb11},
    '{2'sb01, 2'sb00}, '{2'sb11, 2'sb00}, '{2'sb00, 2'sb01}, '{2'sb00, 2'sb11}
  };

endpackage

// ----- hdl/gradient_noise_2d_unit.sv -----
// Channel | Ports                                                   | Handshake
// input   | in_action in_entry_index in_entry_value in_x_coord      | start && !busy
//         | in_y_coord                                              |
// result  | out_noise out_level                                     | out_valid, 1 cycle
//
// One transaction per cycle while busy is low, ten-stage pipeline: a result
// leaves for each evaluate transaction taken; a load transaction gives none.
// The throughput is set by the three permutation table copies, each read at
// two addresses per cycle, and the five-multiply fade pipelines.
// busy is high only during reset and the cycle after; synchronous reset clears
// the valid bits. The receiver cannot stall, so nothing in the pipeline holds.
// TABLE_SIZE must be a power of two.
module gradient_noise_2d_unit #(
  parameter int TABLE_SIZE = gn2d_pkg::TABLE_SIZE_DEF,
  parameter int FRAC_BITS  = gn2d_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_action,
  input  logic [gn2d_pkg::ENTRY_W-1:0]        in_entry_index,
  input  logic [gn2d_pkg::ENTRY_W-1:0]        in_entry_value,
  input  logic [gn2d_pkg::COORD_W-1:0]        in_x_coord,
  input  logic [gn2d_pkg::COORD_W-1:0]        in_y_coord,
  output logic                                out_valid,
  output logic signed [gn2d_pkg::NOISE_W-1:0] out_noise,
  output logic [gn2d_pkg::LEVEL_W-1:0]        out_level
);

  localparam int IW  = $clog2(TABLE_SIZE);
  localparam int EW  = gn2d_pkg::ENTRY_W;
  localparam int SW  = ((IW > EW) ? IW : EW) + 1;
  localparam int W   = FRAC_BITS + 6;
  localparam int NW  = W + gn2d_pkg::OUT_FRAC;
  localparam int LW  = W + 5;
  localparam int SHR = (FRAC_BITS >= gn2d_pkg::OUT_FRAC) ? FRAC_BITS - gn2d_pkg::OUT_FRAC : 0;
  localparam int SHL = (FRAC_BITS < gn2d_pkg::OUT_FRAC) ? gn2d_pkg::OUT_FRAC - FRAC_BITS : 0;
  localparam logic signed [W-1:0]  ONE   = {{(W-1){1'b0}}, 1'b1} <<< FRAC_BITS;
  localparam logic signed [LW-1:0] ONE_L = {{(LW-1){1'b0}}, 1'b1} <<< FRAC_BITS;

  function automatic logic signed [W-1:0] corner(
    logic [gn2d_pkg::HASH_W-1:0] h,
    logic signed [W-1:0]         dx,
    logic signed [W-1:0]         dy
  );
    gn2d_pkg::grad_t     g;
    logic signed [W-1:0] tx, ty;
    g  = gn2d_pkg::GRAD_DIR[h];
    tx = (g.gx == 2'sb01) ? dx : ((g.gx == 2'sb11) ? -dx : '0);
    ty = (g.gy == 2'sb01) ? dy : ((g.gy == 2'sb11) ? -dy : '0);
    return tx + ty;
  endfunction

  logic busy_r;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // stage 1: corner columns from table copy A
  logic [EW-1:0] mem_a [TABLE_SIZE];
  logic [IW-1:0] xi0, xi1, yi_in, wr_idx;
  logic          s1_vld_r, s1_act_r;
  logic [IW-1:0] s1_yi_r, s1_idx_r;
  logic [EW-1:0] s1_val_r, s1_px0_r, s1_px1_r;
  logic [FRAC_BITS-1:0] s1_xf_r, s1_yf_r;

  always_comb begin
    xi0    = IW'(in_x_coord >> FRAC_BITS);
    xi1    = xi0 + IW'(1);
    yi_in  = IW'(in_y_coord >> FRAC_BITS);
    wr_idx = IW'(in_entry_index);
  end

  always_ff @(posedge clk) begin
    if (accept && in_action == gn2d_pkg::ACT_LOAD) begin
      mem_a[wr_idx] <= in_entry_value;
    end
    s1_px0_r <= mem_a[xi0];
    s1_px1_r <= mem_a[xi1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_act_r <= in_action;
    s1_idx_r <= wr_idx;
    s1_val_r <= in_entry_value;
    s1_yi_r  <= yi_in;
    s1_xf_r  <= in_x_coord[FRAC_BITS-1:0];
    s1_yf_r  <= in_y_coord[FRAC_BITS-1:0];
  end

  // stage 2: corner hashes from copies B and C, written in step with their reads
  logic [EW-1:0] mem_b [TABLE_SIZE];
  logic [EW-1:0] mem_c [TABLE_SIZE];
  logic [IW-1:0] ha0, ha1, hb0, hb1;
  logic          s1_load;
  logic [EW-1:0] s2_h00_r, s2_h01_r, s2_h10_r, s2_h11_r;
  logic [FRAC_BITS-1:0] s2_xf_r, s2_yf_r;

  always_comb begin
    s1_load = s1_vld_r && s1_act_r == gn2d_pkg::ACT_LOAD;
    ha0     = IW'(SW'(s1_px0_r) + SW'(s1_yi_r));
    ha1     = IW'(SW'(s1_px0_r) + SW'(s1_yi_r) + SW'(1));
    hb0     = IW'(SW'(s1_px1_r) + SW'(s1_yi_r));
    hb1     = IW'(SW'(s1_px1_r) + SW'(s1_yi_r) + SW'(1));
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      mem_b[s1_idx_r] <= s1_val_r;
      mem_c[s1_idx_r] <= s1_val_r;
    end
    s2_h00_r <= mem_b[ha0];
    s2_h01_r <= mem_b[ha1];
    s2_h10_r <= mem_c[hb0];
    s2_h11_r <= mem_c[hb1];
    s2_xf_r  <= s1_xf_r;
    s2_yf_r  <= s1_yf_r;
  end

  // fade weights, valid in the same cycle as the stage 6 registers
  logic signed [W-1:0] u_w, v_w;

  gn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (.clk(clk), .t(s1_xf_r), .u(u_w));
  gn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (.clk(clk), .t(s1_yf_r), .u(v_w));

  // stages 3..10
  logic [10:2] ev_r;
  logic signed [W-1:0] dx0, dx1, dy0, dy1;
  logic signed [W-1:0] s3_g00_r, s3_g01_r, s3_g10_r, s3_g11_r;
  logic signed [W-1:0] s4_a0_r, s4_d0_r, s4_a1_r, s4_d1_r;
  logic signed [W-1:0] s5_a0_r, s5_d0_r, s5_a1_r, s5_d1_r;
  logic signed [W-1:0] s6_a0_r, s6_d0_r, s6_a1_r, s6_d1_r;
  logic signed [2*W-1:0] pb0, pb1, pn;
  logic signed [W-1:0] b0_nxt, b1_nxt, n_nxt;
  logic signed [W-1:0] s7_b0_r, s7_b1_r, s7_v_r;
  logic signed [W-1:0] s8_b0_r, s8_bd_r, s8_v_r;
  logic signed [W-1:0] s9_n_r;
  logic signed [NW-1:0] nq;
  logic signed [LW-1:0] lm, lq, lv;
  logic signed [gn2d_pkg::NOISE_W-1:0] noise_nxt, s10_noise_r;
  logic [gn2d_pkg::LEVEL_W-1:0] level_nxt, s10_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r <= '0;
    end else begin
      ev_r <= {ev_r[9:2], s1_vld_r && s1_act_r == gn2d_pkg::ACT_EVAL};
    end
  end

  always_comb begin
    dx0    = $signed({{(W-FRAC_BITS){1'b0}}, s2_xf_r});
    dy0    = $signed({{(W-FRAC_BITS){1'b0}}, s2_yf_r});
    dx1    = dx0 - ONE;
    dy1    = dy0 - ONE;
    pb0    = u_w * s6_d0_r;
    pb1    = u_w * s6_d1_r;
    b0_nxt = s6_a0_r + W'(pb0 >>> FRAC_BITS);
    b1_nxt = s6_a1_r + W'(pb1 >>> FRAC_BITS);
    pn     = s8_v_r * s8_bd_r;
    n_nxt  = s8_b0_r + W'(pn >>> FRAC_BITS);
  end

  // output scaling: saturated Q2.14 and a level truncated toward zero
  always_comb begin
    nq = (NW'(s9_n_r) >>> SHR) <<< SHL;
    if (nq > NW'(gn2d_pkg::NOISE_MAX)) begin
      noise_nxt = gn2d_pkg::NOISE_W'(gn2d_pkg::NOISE_MAX);
    end else if (nq < NW'(gn2d_pkg::NOISE_MIN)) begin
      noise_nxt = gn2d_pkg::NOISE_W'(gn2d_pkg::NOISE_MIN);
    end else begin
      noise_nxt = gn2d_pkg::NOISE_W'(nq);
    end
    lm = (LW'(s9_n_r) + ONE_L) * LW'(gn2d_pkg::LEVEL_SCALE);
    lq = lm >>> (FRAC_BITS + 1);
    if (lm < 0 && |lm[FRAC_BITS:0]) begin
      lq = lq + LW'(1);
    end
    lv = lq + LW'(1);
    if (lv < LW'(gn2d_pkg::LEVEL_MIN)) begin
      level_nxt = gn2d_pkg::LEVEL_W'(gn2d_pkg::LEVEL_MIN);
    end else if (lv > LW'(gn2d_pkg::LEVEL_MAX)) begin
      level_nxt = gn2d_pkg::LEVEL_W'(gn2d_pkg::LEVEL_MAX);
    end else begin
      level_nxt = gn2d_pkg::LEVEL_W'(lv);
    end
  end

  always_ff @(posedge clk) begin
    s3_g00_r    <= corner(s2_h00_r[gn2d_pkg::HASH_W-1:0], dx0, dy0);
    s3_g10_r    <= corner(s2_h10_r[gn2d_pkg::HASH_W-1:0], dx1, dy0);
    s3_g01_r    <= corner(s2_h01_r[gn2d_pkg::HASH_W-1:0], dx0, dy1);
    s3_g11_r    <= corner(s2_h11_r[gn2d_pkg::HASH_W-1:0], dx1, dy1);
    s4_a0_r     <= s3_g00_r;
    s4_d0_r     <= s3_g10_r - s3_g00_r;
    s4_a1_r     <= s3_g01_r;
    s4_d1_r     <= s3_g11_r - s3_g01_r;
    s5_a0_r     <= s4_a0_r;
    s5_d0_r     <= s4_d0_r;
    s5_a1_r     <= s4_a1_r;
    s5_d1_r     <= s4_d1_r;
    s6_a0_r     <= s5_a0_r;
    s6_d0_r     <= s5_d0_r;
    s6_a1_r     <= s5_a1_r;
    s6_d1_r     <= s5_d1_r;
    s7_b0_r     <= b0_nxt;
    s7_b1_r     <= b1_nxt;
    s7_v_r      <= v_w;
    s8_b0_r     <= s7_b0_r;
    s8_bd_r     <= s7_b1_r - s7_b0_r;
    s8_v_r      <= s7_v_r;
    s9_n_r      <= n_nxt;
    s10_noise_r <= noise_nxt;
    s10_level_r <= level_nxt;
  end

  assign out_valid = ev_r[10];
  assign out_noise = s10_noise_r;
  assign out_level = s10_level_r;

endmodule

// ----- hdl/gn2d_fade.sv -----
module gn2d_fade #(
  parameter int FRAC_BITS = gn2d_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic [FRAC_BITS-1:0]        t,
  output logic signed [FRAC_BITS+5:0] u
);

  localparam int W = FRAC_BITS + 6;
  localparam logic signed [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1} <<< FRAC_BITS;
  localparam logic signed [W-1:0] C6  = W'(gn2d_pkg::FADE_C6);
  localparam logic signed [W-1:0] K15 = W'(gn2d_pkg::FADE_C15) * ONE;
  localparam logic signed [W-1:0] K10 = W'(gn2d_pkg::FADE_C10) * ONE;

  // 6t^5 - 15t^4 + 10t^3 in Horner form, one multiply per stage
  logic signed [W-1:0]   t_ext;
  logic signed [W-1:0]   r0_nxt, r1_nxt, r2_nxt, r3_nxt, u_nxt;
  logic signed [2*W-1:0] p1, p2, p3, p4;
  logic signed [W-1:0]   r0_r, r1_r, r2_r, r3_r, u_r;
  logic signed [W-1:0]   t1_r, t2_r, t3_r, t4_r;

  always_comb begin
    t_ext  = $signed({{(W-FRAC_BITS){1'b0}}, t});
    r0_nxt = t_ext * C6 - K15;
    p1     = t1_r * r0_r;
    r1_nxt = W'(p1 >>> FRAC_BITS) + K10;
    p2     = t2_r * r1_r;
    r2_nxt = W'(p2 >>> FRAC_BITS);
    p3     = t3_r * r2_r;
    r3_nxt = W'(p3 >>> FRAC_BITS);
    p4     = t4_r * r3_r;
    u_nxt  = W'(p4 >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    r0_r <= r0_nxt;
    t1_r <= t_ext;
    r1_r <= r1_nxt;
    t2_r <= t1_r;
    r2_r <= r2_nxt;
    t3_r <= t2_r;
    r3_r <= r3_nxt;
    t4_r <= t3_r;
    u_r  <= u_nxt;
  end

  assign u = u_r;

endmodule
